/* sv/assert_macros.svh */
// Assertion macros shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked on every clock edge outside reset.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// Next-cycle implication checked outside reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`endif

/* sv/drs_pkg.sv */
// ----------------------------------------------------------------------------
// drs_pkg
// Constants and types shared by the deadline request scheduler.
// ----------------------------------------------------------------------------
package drs_pkg;
    localparam int NUM_TAGS    = 64;
    localparam int TAG_W       = $clog2(NUM_TAGS);
    localparam int CNT_W       = $clog2(NUM_TAGS + 1);
    localparam int SECTOR_BITS = 48;

    localparam logic [1:0] CMD_INSERT   = 2'd0;
    localparam logic [1:0] CMD_DISPATCH = 2'd1;
    localparam logic [1:0] CMD_TICK     = 2'd2;
    localparam logic [1:0] CMD_NONE     = 2'd3;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_EMPTY = 2'd1;
    localparam logic [1:0] ST_DUP   = 2'd2;
    localparam logic [1:0] ST_TICK  = 2'd3;

    localparam logic [1:0] CFG_READ_EXP  = 2'd0;
    localparam logic [1:0] CFG_WRITE_EXP = 2'd1;
    localparam logic [1:0] CFG_STARVE    = 2'd2;

    // Scan request to the table unit and its answers.
    typedef struct packed {
        logic             start;
        logic             find_succ;
        logic             dir;
        logic [TAG_W-1:0] ref_tag;
    } t_scan_req;

    typedef struct packed {
        logic             done;
        logic             found_r;
        logic [TAG_W-1:0] tag_r;
        logic             found_w;
        logic [TAG_W-1:0] tag_w;
    } t_scan_rsp;
endpackage

/* sv/drs_scan.sv */
// ----------------------------------------------------------------------------
// drs_scan
// Sequential scan over the request table: oldest per direction or successor.
// ----------------------------------------------------------------------------
module drs_scan import drs_pkg::*; (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  t_scan_req              i_req,
    input  logic [NUM_TAGS-1:0]    i_sorted_r,
    input  logic [NUM_TAGS-1:0]    i_sorted_w,
    input  logic [31:0]            i_arrival_counter,
    input  logic [SECTOR_BITS-1:0] i_rd_sector,
    input  logic [31:0]            i_rd_arrival,
    output logic [TAG_W-1:0]       o_rd_addr,
    output t_scan_rsp              o_rsp
);
    logic                   r_busy, r_first;
    logic                   r_succ, r_dir;
    logic [TAG_W:0]         r_idx;
    logic [TAG_W-1:0]       r_ref;
    logic [SECTOR_BITS-1:0] r_ref_sec;
    logic [31:0]            r_ref_age;
    logic                   r_fr, r_fw;
    logic [TAG_W-1:0]       r_tr, r_tw;
    logic [31:0]            r_age_r, r_age_w;
    logic [SECTOR_BITS-1:0] r_sec_b;
    logic                   r_done;

    logic [TAG_W-1:0]       cur;
    logic [31:0]            age;
    logic                   ref_before, cand_before;

    assign cur = r_idx[TAG_W-1:0] - TAG_W'(1);
    assign o_rd_addr = r_first ? r_ref : r_idx[TAG_W-1:0];
    assign age = i_arrival_counter - i_rd_arrival;

    // Data at cycle k belongs to entry cur (address issued in the previous cycle).
    assign ref_before  = (r_ref_sec != i_rd_sector) ? (r_ref_sec < i_rd_sector)
                                                    : (r_ref_age > age);
    assign cand_before = (i_rd_sector != r_sec_b) ? (i_rd_sector < r_sec_b)
                                                  : (age > r_age_r);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy  <= 1'b1;
                r_first <= i_req.find_succ;
                r_succ  <= i_req.find_succ;
                r_dir   <= i_req.dir;
                r_ref   <= i_req.ref_tag;
                r_idx   <= '0;
                r_fr    <= 1'b0;
                r_fw    <= 1'b0;
            end else if (r_busy) begin
                if (r_first) begin
                    r_first <= 1'b0;
                end else if (r_idx == '0) begin
                    r_idx <= r_idx + 1'b1;
                    if (r_succ) begin
                        r_ref_sec <= i_rd_sector;
                        r_ref_age <= age;
                    end
                end else begin
                    if (r_succ) begin
                        if ((r_dir ? i_sorted_w[cur] : i_sorted_r[cur]) && cur != r_ref
                            && ref_before && (!r_fr || cand_before)) begin
                            r_fr    <= 1'b1;
                            r_tr    <= cur;
                            r_sec_b <= i_rd_sector;
                            r_age_r <= age;
                        end
                    end else begin
                        if (i_sorted_r[cur] && (!r_fr || age > r_age_r)) begin
                            r_fr <= 1'b1; r_tr <= cur; r_age_r <= age;
                        end
                        if (i_sorted_w[cur] && (!r_fw || age > r_age_w)) begin
                            r_fw <= 1'b1; r_tw <= cur; r_age_w <= age;
                        end
                    end
                    if (r_idx == (TAG_W+1)'(NUM_TAGS)) begin
                        r_busy <= 1'b0;
                        r_done <= 1'b1;
                    end else begin
                        r_idx <= r_idx + 1'b1;
                    end
                end
            end
        end
    end

    // The first compare cycle must skip the reference load when not needed.
    assign o_rsp.done    = r_done;
    assign o_rsp.found_r = r_fr;
    assign o_rsp.tag_r   = r_tr;
    assign o_rsp.found_w = r_fw;
    assign o_rsp.tag_w   = r_tw;
endmodule

/* sv/deadline_request_scheduler.sv */
// ----------------------------------------------------------------------------
// deadline_request_scheduler
// Deadline disk-request scheduler with bypass list and starvation control.
// ----------------------------------------------------------------------------
// Usage: commands enter on the s_axis channel (insert, dispatch, tick) and
// each produces exactly one result transaction on m_axis. An insert or a tick
// passes from acceptance through the execute and output states. A dispatch
// served from the bypass list passes through the execute, read and output
// states. Otherwise it runs two sequential scans of the 64-entry table
// through one shared compare unit: the oldest per direction and then the
// sector successor; a dispatch that finds nothing skips the successor scan.
// The table is a single-read-port memory, which sets the scan length. The
// block accepts one command at a time and is ready again as soon as the
// previous result sits in the output register. If the receiver stalls, the
// result waits there; a following command is still processed but holds its
// own result back until the register is free, and no further command is
// taken meanwhile. Reset empties the queue, clears time and counters and
// loads the register defaults (125, 1250, 2).
// Configuration is written via i_cfg_we, i_cfg_index and i_cfg_data while idle.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"
module deadline_request_scheduler import drs_pkg::*; (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_cfg_we,
    input  logic [1:0]   i_cfg_index,
    input  logic [31:0]  i_cfg_data,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // tdata: cmd[1:0], req_tag[7:2], req_dir[8], req_sector[56:9],
    // bypass[57], at_head[58], zero fill [63:59]
    input  logic [63:0]  s_axis_tdata,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // tdata: status[1:0], out_tag[7:2], out_dir[8], out_sector[56:9],
    // work_left[57], zero fill [63:58]
    output logic [63:0]  m_axis_tdata
);
    localparam logic [2:0] S_IDLE = 3'd0, S_EXEC = 3'd1, S_OLD = 3'd2,
                           S_DEC = 3'd3, S_SUCC = 3'd4, S_OUT = 3'd5,
                           S_RD = 3'd6;

    logic [2:0]  r_state;
    logic [31:0] r_rexp, r_wexp, r_now, r_arr;
    logic [7:0]  r_limit, r_starve;
    logic [1:0]  r_cmd;
    logic [TAG_W-1:0] r_tag;
    logic        r_dir_in, r_byp, r_head;
    logic [SECTOR_BITS-1:0] r_sec_in;

    logic [NUM_TAGS-1:0] r_valid, r_bypd, r_edir;
    logic [TAG_W-1:0]    r_bhead;
    logic [CNT_W-1:0]    r_bcnt;
    logic [TAG_W-1:0]    r_blist [NUM_TAGS];
    logic [TAG_W-1:0]    r_bl_rd;
    logic                r_nv [2];
    logic [TAG_W-1:0]    r_nt [2];

    logic [SECTOR_BITS-1:0] r_msec [NUM_TAGS];
    logic [31:0]            r_mdl  [NUM_TAGS];
    logic [31:0]            r_marr [NUM_TAGS];
    logic [SECTOR_BITS-1:0] r_rd_sec;
    logic [31:0]            r_rd_dl, r_rd_arr;
    logic [TAG_W-1:0]       rd_addr, scan_addr;

    logic        r_pick_dir, r_have_pick;
    logic [TAG_W-1:0] r_pick;
    logic [1:0]  r_status;
    logic        r_ovalid;
    logic [63:0] r_odata;

    t_scan_req   scan_req;
    t_scan_rsp   scan_rsp;
    logic [NUM_TAGS-1:0] sorted_r, sorted_w;

    assign sorted_r = r_valid & ~r_bypd & ~r_edir;
    assign sorted_w = r_valid & ~r_bypd &  r_edir;

    drs_scan u_scan (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_req(scan_req),
        .i_sorted_r(sorted_r), .i_sorted_w(sorted_w),
        .i_arrival_counter(r_arr), .i_rd_sector(r_rd_sec),
        .i_rd_arrival(r_rd_arr), .o_rd_addr(scan_addr), .o_rsp(scan_rsp)
    );

    // Table read port: scanner address, or the chosen entry while it is read, when
    // deciding and while its result is being formed.
    assign rd_addr = (r_state == S_DEC || r_state == S_RD || r_state == S_OUT) ? r_pick
                                                                             : scan_addr;

    always_ff @(posedge i_clk) begin
        r_rd_sec <= r_msec[rd_addr];
        r_rd_dl  <= r_mdl[rd_addr];
        r_rd_arr <= r_marr[rd_addr];
        r_bl_rd  <= r_blist[r_bhead];
    end

    assign s_axis_tready = (r_state == S_IDLE);
    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = r_odata;

    logic        d_sel;
    logic [TAG_W-1:0] nxt;
    logic        nxt_ok, expired;
    logic [31:0] slack;
    assign d_sel   = r_pick_dir;
    assign nxt     = r_nt[d_sel];
    assign nxt_ok  = r_nv[d_sel] && (d_sel ? sorted_w[nxt] : sorted_r[nxt]);
    assign slack   = r_now - r_rd_dl;
    assign expired = !slack[31];

    always_comb begin
        scan_req = '0;
        scan_req.dir     = r_pick_dir;
        scan_req.ref_tag = r_pick;
        if (r_state == S_EXEC && r_cmd == CMD_DISPATCH && r_bcnt == '0)
            scan_req.start = 1'b1;
        if (r_state == S_DEC) begin
            scan_req.start     = 1'b1;
            scan_req.find_succ = 1'b1;
            if (!(expired || !nxt_ok)) scan_req.ref_tag = nxt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_rexp   <= 32'd125;
            r_wexp   <= 32'd1250;
            r_limit  <= 8'd2;
            r_now    <= '0;
            r_arr    <= '0;
            r_starve <= '0;
            r_valid  <= '0;
            r_bypd   <= '0;
            r_bhead  <= '0;
            r_bcnt   <= '0;
            r_nv[0]  <= 1'b0;
            r_nv[1]  <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    CFG_READ_EXP:  r_rexp  <= i_cfg_data;
                    CFG_WRITE_EXP: r_wexp  <= i_cfg_data;
                    CFG_STARVE:    r_limit <= i_cfg_data[7:0];
                    default: ;
                endcase
            end
            if (r_ovalid && m_axis_tready) r_ovalid <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (s_axis_tvalid && s_axis_tready) begin
                        r_cmd    <= s_axis_tdata[1:0];
                        r_tag    <= s_axis_tdata[7:2];
                        r_dir_in <= s_axis_tdata[8];
                        r_sec_in <= s_axis_tdata[56:9];
                        r_byp    <= s_axis_tdata[57];
                        r_head   <= s_axis_tdata[58];
                        r_state  <= S_EXEC;
                    end
                end
                S_EXEC: begin
                    r_have_pick <= 1'b0;
                    r_status    <= ST_OK;
                    r_state     <= S_OUT;
                    case (r_cmd)
                        CMD_INSERT: begin
                            if (r_valid[r_tag]) begin
                                r_status <= ST_DUP;
                            end else begin
                                r_valid[r_tag] <= 1'b1;
                                r_edir[r_tag]  <= r_dir_in;
                                r_msec[r_tag]  <= r_sec_in;
                                if (r_byp || r_head) begin
                                    r_bypd[r_tag] <= 1'b1;
                                    if (r_head) begin
                                        r_bhead <= r_bhead - 1'b1;
                                        r_blist[r_bhead - 1'b1] <= r_tag;
                                    end else begin
                                        r_blist[r_bhead + r_bcnt[TAG_W-1:0]] <= r_tag;
                                    end
                                    r_bcnt <= r_bcnt + 1'b1;
                                end else begin
                                    r_bypd[r_tag] <= 1'b0;
                                    r_mdl[r_tag]  <= r_now + (r_dir_in ? r_wexp : r_rexp);
                                    r_marr[r_tag] <= r_arr;
                                    r_arr <= r_arr + 1'b1;
                                end
                            end
                        end
                        CMD_DISPATCH: begin
                            if (r_bcnt != '0) begin
                                r_pick      <= r_bl_rd;
                                r_have_pick <= 1'b1;
                                r_valid[r_bl_rd] <= 1'b0;
                                r_bypd[r_bl_rd]  <= 1'b0;
                                r_bhead <= r_bhead + 1'b1;
                                r_bcnt  <= r_bcnt - 1'b1;
                                r_state <= S_RD;
                            end else begin
                                r_state <= S_OLD;
                            end
                        end
                        CMD_TICK: begin
                            r_now    <= r_now + 1'b1;
                            r_status <= ST_TICK;
                        end
                        default: ;
                    endcase
                end
                S_OLD: begin
                    if (scan_rsp.done) begin
                        if (!scan_rsp.found_r && !scan_rsp.found_w) begin
                            r_status <= ST_EMPTY;
                            r_state  <= S_OUT;
                        end else begin
                            if (scan_rsp.found_r && scan_rsp.found_w) begin
                                if (r_starve != 8'hFF) r_starve <= r_starve + 1'b1;
                            end
                            if (!scan_rsp.found_r || (scan_rsp.found_w && r_starve >= r_limit)) begin
                                r_pick_dir <= 1'b1;
                                r_pick     <= scan_rsp.tag_w;
                                r_starve   <= '0;
                            end else begin
                                r_pick_dir <= 1'b0;
                                r_pick     <= scan_rsp.tag_r;
                            end
                            r_state <= S_RD;
                        end
                    end
                end
                S_RD: begin
                    // The chosen entry's deadline and sector are being read from the table.
                    r_state <= r_have_pick ? S_OUT : S_DEC;
                end
                S_DEC: begin
                    if (!(expired || !nxt_ok)) r_pick <= nxt;
                    r_have_pick <= 1'b1;
                    r_state     <= S_SUCC;
                end
                S_SUCC: begin
                    if (scan_rsp.done) begin
                        r_nv[0] <= 1'b0;
                        r_nv[1] <= 1'b0;
                        r_nv[r_pick_dir] <= scan_rsp.found_r;
                        r_nt[r_pick_dir] <= scan_rsp.tag_r;
                        r_valid[r_pick]  <= 1'b0;
                        r_state <= S_RD;
                    end
                end
                S_OUT: begin
                    if (!r_ovalid) begin
                        r_odata <= {6'd0, |r_valid,
                                    r_have_pick ? r_rd_sec : {SECTOR_BITS{1'b0}},
                                    r_have_pick ? r_edir[r_pick] : 1'b0,
                                    r_have_pick ? r_pick : {TAG_W{1'b0}}, r_status};
                        r_ovalid <= 1'b1;
                        r_state  <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    `ASSERT_IMPL(a_ready_idle, i_clk, i_rst_n, s_axis_tready, r_state == S_IDLE, "ready outside idle")
    `ASSERT_NEXT(a_one_result, i_clk, i_rst_n, s_axis_tvalid && s_axis_tready, !m_axis_tvalid || m_axis_tready || $stable(m_axis_tdata), "result lost")
    `ASSERT_IMPL(a_bcnt, i_clk, i_rst_n, 1'b1, r_bcnt <= CNT_W'(NUM_TAGS), "bypass count overflow")
endmodule

/* sim/deadline_request_scheduler_tb.sv */
// ----------------------------------------------------------------------------
// deadline_request_scheduler_tb
// Self-checking testbench for the deadline request scheduler. A queue of
// commands (inserts, dispatches and ticks) feeds a stream driver with random
// gaps, a monitor with random back-pressure collects results, and a
// behavioural scheduler model predicts every result transaction field by
// field. Configuration is rewritten between phases while the block is idle.
// ----------------------------------------------------------------------------
module deadline_request_scheduler_tb;
    import drs_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int    NONE        = 255;
    localparam int    CYCLE_LIMIT = 2000000;
    localparam int    SETTLE      = 300;
    localparam int    PHASES      = 5;
    localparam int    PHASE_ITEMS = 130;

    typedef struct packed {
        logic                   at_head;
        logic                   bypass;
        logic [SECTOR_BITS-1:0] sector;
        logic                   dir;
        logic [TAG_W-1:0]       tag;
        logic [1:0]             cmd;
    } t_cmd;

    typedef struct packed {
        logic                   work_left;
        logic [SECTOR_BITS-1:0] sector;
        logic                   dir;
        logic [TAG_W-1:0]       tag;
        logic [1:0]             status;
    } t_res;

    logic         i_clk = 1'b0;
    logic         i_rst_n = 1'b0;
    logic         i_cfg_we = 1'b0;
    logic [1:0]   i_cfg_index = '0;
    logic [31:0]  i_cfg_data = '0;
    logic         s_axis_tvalid = 1'b0;
    logic         s_axis_tready;
    logic [63:0]  s_axis_tdata = '0;
    logic         m_axis_tvalid;
    logic         m_axis_tready = 1'b0;
    logic [63:0]  m_axis_tdata;

    deadline_request_scheduler u_top (.*);

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // Scheduler model state.
    logic [31:0]            rd_expire, wr_expire;
    logic [7:0]             starve_limit, starved;
    logic [31:0]            now_ticks, arrivals;
    bit                     q_valid[NUM_TAGS], q_byp[NUM_TAGS];
    logic                   q_dir[NUM_TAGS];
    logic [SECTOR_BITS-1:0] q_sector[NUM_TAGS];
    logic [31:0]            q_deadline[NUM_TAGS], q_arrival[NUM_TAGS];
    int                     bypass_fifo[$];
    int                     next_seq[2];

    t_cmd  pending_cmds[$];
    t_res  expected_results[$];
    int    mismatches = 0;
    longint cycles = 0;
    bit    stream_open = 1'b0;

    function automatic bit sorted_in(int i, logic d);
        return q_valid[i] && !q_byp[i] && q_dir[i] == d;
    endfunction

    function automatic logic [31:0] age(int i);
        return arrivals - q_arrival[i];
    endfunction

    function automatic int oldest_of(logic d);
        int best;
        best = NONE;
        for (int i = 0; i < NUM_TAGS; i++)
            if (sorted_in(i, d) && (best == NONE || age(i) > age(best))) best = i;
        return best;
    endfunction

    function automatic bit ahead_of(int a, int b);
        if (q_sector[a] != q_sector[b]) return q_sector[a] < q_sector[b];
        return age(a) > age(b);
    endfunction

    function automatic int next_by_sector(int r, logic d);
        int best;
        best = NONE;
        for (int i = 0; i < NUM_TAGS; i++) begin
            if (i == r || !sorted_in(i, d) || !ahead_of(r, i)) continue;
            if (best == NONE || ahead_of(i, best)) best = i;
        end
        return best;
    endfunction

    function automatic void clear_schedule();
        rd_expire = 125; wr_expire = 1250; starve_limit = 2;
        for (int i = 0; i < NUM_TAGS; i++) begin
            q_valid[i] = 0; q_byp[i] = 0;
        end
        bypass_fifo.delete();
        next_seq[0] = NONE; next_seq[1] = NONE;
        starved = 0; now_ticks = 0; arrivals = 0;
    endfunction

    function automatic t_res schedule_step(t_cmd c);
        t_res r;
        int pick, old_r, old_w, d, nxt;
        logic [7:0] prev;
        logic [31:0] slack;
        bit expired, busy;
        r = '0;
        pick = NONE;
        case (c.cmd)
            CMD_INSERT: begin
                if (q_valid[c.tag]) r.status = ST_DUP;
                else begin
                    r.status = ST_OK;
                    q_valid[c.tag] = 1; q_dir[c.tag] = c.dir; q_sector[c.tag] = c.sector;
                    if (c.bypass || c.at_head) begin
                        q_byp[c.tag] = 1;
                        if (c.at_head) bypass_fifo.push_front(c.tag);
                        else bypass_fifo.push_back(c.tag);
                    end else begin
                        q_byp[c.tag] = 0;
                        q_deadline[c.tag] = now_ticks + (c.dir ? wr_expire : rd_expire);
                        q_arrival[c.tag] = arrivals;
                        arrivals++;
                    end
                end
            end
            CMD_DISPATCH: begin
                r.status = ST_OK;
                if (bypass_fifo.size() > 0) begin
                    pick = bypass_fifo.pop_front();
                    q_valid[pick] = 0; q_byp[pick] = 0;
                end else begin
                    old_r = oldest_of(1'b0); old_w = oldest_of(1'b1);
                    d = 2;
                    if (old_r != NONE) begin
                        d = 0;
                        if (old_w != NONE) begin
                            prev = starved;
                            if (starved != 8'd255) starved++;
                            if (prev >= starve_limit) d = 1;
                        end
                    end else if (old_w != NONE) d = 1;
                    if (d == 2) r.status = ST_EMPTY;
                    else begin
                        if (d == 1) starved = 0;
                        nxt = next_seq[d];
                        if (nxt != NONE && !sorted_in(nxt, d[0])) nxt = NONE;
                        pick = d ? old_w : old_r;
                        slack = now_ticks - q_deadline[pick];
                        expired = !slack[31];
                        if (!expired && nxt != NONE) pick = nxt;
                        next_seq[0] = NONE; next_seq[1] = NONE;
                        next_seq[d] = next_by_sector(pick, d[0]);
                        q_valid[pick] = 0;
                    end
                end
            end
            CMD_TICK: begin
                now_ticks++;
                r.status = ST_TICK;
            end
            default: r.status = ST_OK;
        endcase
        if (pick != NONE) begin
            r.tag = pick[TAG_W-1:0]; r.dir = q_dir[pick]; r.sector = q_sector[pick];
        end
        busy = 0;
        for (int i = 0; i < NUM_TAGS; i++) busy |= q_valid[i];
        r.work_left = busy;
        return r;
    endfunction

    function automatic int gap_len();
        if ($urandom_range(3) == 0) return 0;
        return ($urandom_range(15) == 0) ? $urandom_range(40, 10) : $urandom_range(3);
    endfunction

    // Driver: the model runs on acceptance so that results line up in order.
    int send_gap = 0;
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (s_axis_tvalid && s_axis_tready)
            expected_results.push_back(schedule_step(t_cmd'(s_axis_tdata[58:0])));
        if (!s_axis_tvalid || s_axis_tready) begin
            if (send_gap > 0 || !stream_open || pending_cmds.size() == 0) begin
                s_axis_tvalid <= 1'b0;
                if (send_gap > 0) send_gap <= send_gap - 1;
            end else begin
                s_axis_tvalid <= 1'b1;
                s_axis_tdata  <= {5'b0, pending_cmds.pop_front()};
                send_gap      <= gap_len();
            end
        end
    end

    // Monitor with random back-pressure.
    int stall = 0;
    always @(posedge i_clk) begin
        t_res got, exp_r;
        if (m_axis_tvalid && m_axis_tready) begin
            got = t_res'(m_axis_tdata[57:0]);
            if (expected_results.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result %h", got);
            end else begin
                exp_r = expected_results.pop_front();
                if (got !== exp_r || m_axis_tdata[63:58] !== '0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: st %0d/%0d tag %0d/%0d dir %0d/%0d sec %h/%h wl %0d/%0d",
                                 exp_r.status, got.status, exp_r.tag, got.tag, exp_r.dir,
                                 got.dir, exp_r.sector, got.sector, exp_r.work_left,
                                 got.work_left);
                end
            end
        end
        if (stall > 0) begin
            stall <= stall - 1;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= 1'b1;
            stall <= gap_len();
        end
    end

    always @(posedge i_clk) begin
        if (cycles > CYCLE_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    function automatic t_cmd make_cmd(logic [1:0] op, int tag, logic d,
                                      logic [SECTOR_BITS-1:0] sec, logic b, logic h);
        t_cmd c;
        c.cmd = op; c.tag = tag[TAG_W-1:0]; c.dir = d; c.sector = sec;
        c.bypass = b; c.at_head = h;
        return c;
    endfunction

    function automatic logic [SECTOR_BITS-1:0] rand_sector();
        case ($urandom_range(3))
            0: return SECTOR_BITS'({$urandom, $urandom});
            1: return SECTOR_BITS'($urandom_range(7));
            2: return {SECTOR_BITS{1'b1}} - SECTOR_BITS'($urandom_range(3));
            default: return SECTOR_BITS'($urandom_range(1000));
        endcase
    endfunction

    // Random inserts of random tags, dispatches, ticks and no-op commands.
    function automatic void queue_random();
        t_cmd c;
        int k;
        k = $urandom_range(99);
        c = make_cmd(CMD_INSERT, int'($urandom_range(NUM_TAGS - 1)), 1'($urandom_range(1)),
                     rand_sector(), $urandom_range(9) == 0, $urandom_range(14) == 0);
        if (k >= 45 && k < 80) c.cmd = CMD_DISPATCH;
        else if (k >= 80 && k < 97) c.cmd = CMD_TICK;
        else if (k >= 97) c.cmd = CMD_NONE;
        pending_cmds.push_back(c);
    endfunction

    task automatic write_reg(logic [1:0] idx, logic [31:0] val);
        @(posedge i_clk);
        i_cfg_we <= 1'b1; i_cfg_index <= idx; i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == CFG_READ_EXP) rd_expire = val;
        else if (idx == CFG_WRITE_EXP) wr_expire = val;
        else starve_limit = val[7:0];
    endtask

    task automatic drain();
        while (pending_cmds.size() > 0 || s_axis_tvalid || expected_results.size() > 0)
            @(posedge i_clk);
        stream_open = 1'b0;
        repeat (SETTLE) @(posedge i_clk);
    endtask

    logic [31:0] rd_set[PHASES] = '{125, 0, 32'hFFFF_FFFF, 3, 20};
    logic [31:0] wr_set[PHASES] = '{1250, 32'hFFFF_FFFF, 0, 5, 40};
    logic [7:0]  lim_set[PHASES] = '{2, 0, 255, 1, 4};

    initial begin
        clear_schedule();
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        // Directed: empty dispatch, bypass head/tail, duplicate, extremes, ticks.
        pending_cmds.push_back(make_cmd(CMD_DISPATCH, 0, 1'b0, '0, 1'b0, 1'b0));
        pending_cmds.push_back(make_cmd(CMD_INSERT, 0, 1'b0, '0, 1'b0, 1'b0));
        pending_cmds.push_back(make_cmd(CMD_INSERT, 0, 1'b1, '1, 1'b0, 1'b0));
        pending_cmds.push_back(make_cmd(CMD_INSERT, 63, 1'b1, '1, 1'b0, 1'b0));
        pending_cmds.push_back(make_cmd(CMD_INSERT, 5, 1'b0, 48'h5555_5555_5555, 1'b1, 1'b0));
        pending_cmds.push_back(make_cmd(CMD_INSERT, 6, 1'b1, 48'hAAAA_AAAA_AAAA, 1'b0, 1'b1));
        pending_cmds.push_back(make_cmd(CMD_INSERT, 7, 1'b0, 48'd10, 1'b1, 1'b1));
        pending_cmds.push_back(make_cmd(CMD_INSERT, 8, 1'b0, 48'd10, 1'b0, 1'b0));
        pending_cmds.push_back(make_cmd(CMD_INSERT, 9, 1'b0, 48'd10, 1'b0, 1'b0));
        pending_cmds.push_back(make_cmd(CMD_INSERT, 10, 1'b0, 48'd3, 1'b0, 1'b0));
        pending_cmds.push_back(make_cmd(CMD_NONE, 63, 1'b1, '1, 1'b1, 1'b1));
        pending_cmds.push_back(make_cmd(CMD_TICK, 0, 1'b0, '0, 1'b0, 1'b0));
        for (int i = 0; i < 9; i++)
            pending_cmds.push_back(make_cmd(CMD_DISPATCH, 0, 1'b0, '0, 1'b0, 1'b0));
        stream_open = 1'b1;
        drain();
        for (int p = 0; p < PHASES; p++) begin
            write_reg(CFG_READ_EXP, rd_set[p]);
            write_reg(CFG_WRITE_EXP, wr_set[p]);
            write_reg(CFG_STARVE, {24'b0, lim_set[p]});
            for (int n = 0; n < PHASE_ITEMS; n++) queue_random();
            // Empty the queue so the next phase starts from a known state.
            for (int n = 0; n < NUM_TAGS + 2; n++)
                pending_cmds.push_back(make_cmd(CMD_DISPATCH, 0, 1'b0, '0, 1'b0, 1'b0));
            stream_open = 1'b1;
            drain();
        end
        if (mismatches == 0 && expected_results.size() == 0) $display("SUCCESS");
        else $display("FAILURE");
        $finish;
    end
endmodule
